>>> hw/rtl/gtq_pkg.sv
// Package with sizes, opcodes, status codes and state type of the team queue.
`timescale 1ns / 1ps
package gtq_pkg;
    localparam int TEAMS          = 1024;
    localparam int MEMBER_ID_BITS = 12;
    localparam int CAPACITY       = 1024;
    localparam int MEMBERS        = 1 << MEMBER_ID_BITS;
    localparam int TW             = $clog2(TEAMS);
    localparam int NW             = $clog2(CAPACITY);
    localparam int MW             = MEMBER_ID_BITS;
    localparam int SWEEP          = (MEMBERS > CAPACITY) ?
                                    ((MEMBERS > TEAMS) ? MEMBERS : TEAMS) :
                                    ((CAPACITY > TEAMS) ? CAPACITY : TEAMS);
    localparam int SW             = $clog2(SWEEP);
    localparam int TEAM_FIELD     = 10;
    localparam int ID_FIELD       = 12;

    localparam logic [1:0] OP_ASSIGN  = 2'd0;
    localparam logic [1:0] OP_ENQUEUE = 2'd1;
    localparam logic [1:0] OP_DEQUEUE = 2'd2;
    localparam logic [1:0] OP_CLEAR   = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_ENQ_RD, S_ENQ_WR, S_DEQ_RD1, S_DEQ_RD2, S_DEQ_WR,
        S_CLEAR, S_OUT
    } state_t;
endpackage

>>> hw/rtl/grouped_team_queue.sv
// Top level of the team queue: control sequencer around the table memories.
// Assign and an empty dequeue give their result straight from idle; an enqueue
// runs through ENQ_RD and ENQ_WR (ENQ_RD alone into a full store), a dequeue
// through DEQ_RD1, DEQ_RD2 and DEQ_WR, a clear through the sweep, then OUT.
// One operation at a time: the next transfer in is taken once the sequencer is
// idle and the result slot frees up; the states follow the dependent memory
// reads of team, node and pointer tables.
// Reset and clear: a sweep over max(members, capacity, teams) addresses rewrites
// the membership, free-slot and waiting tables; no input is accepted meanwhile.
`timescale 1ns / 1ps
module grouped_team_queue
    import gtq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // opcode[1:0], member_id[13:2], team_id[23:14]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[1:0], out_member[13:2], zero[15:14]
);
    state_t state_reg, state_next;
    logic [1:0]  op_reg, op_next;
    logic [MW-1:0] mem_reg, mem_next;
    logic [TW-1:0] team_reg, team_next;
    logic [NW-1:0] node_reg, node_next;
    logic [NW:0]   fcnt_reg, fcnt_next;
    logic [TW-1:0] rptr_reg, rptr_next, wptr_reg, wptr_next;
    logic [TW:0]   acnt_reg, acnt_next;
    logic [SW:0]   swp_reg, swp_next;
    logic          ov_reg, ov_next;
    logic [1:0]    ost_reg, ost_next;
    logic [MW-1:0] omem_reg, omem_next;
    logic          wait_reg, wait_next;

    // memory ports
    logic mt_we; logic [MW-1:0] mt_wa, mt_ra; logic [TW-1:0] mt_wd, mt_rd;
    logic nm_we; logic [NW-1:0] nm_wa, nm_ra; logic [MW-1:0] nm_wd, nm_rd;
    logic nx_we; logic [NW-1:0] nx_wa, nx_ra; logic [NW-1:0] nx_wd, nx_rd;
    logic fs_we; logic [NW-1:0] fs_wa, fs_ra; logic [NW-1:0] fs_wd, fs_rd;
    logic th_we; logic [TW-1:0] th_wa, th_ra; logic [NW-1:0] th_wd, th_rd;
    logic tt_we; logic [TW-1:0] tt_wa, tt_ra; logic [NW-1:0] tt_wd, tt_rd;
    logic tw_we; logic [TW-1:0] tw_wa, tw_ra; logic [0:0]    tw_wd, tw_rd;
    logic at_we; logic [TW-1:0] at_wa, at_ra; logic [TW-1:0] at_wd, at_rd;

    gtq_ram #(.WIDTH(TW), .DEPTH(MEMBERS)) u_member_team (.aclk(aclk), .we(mt_we),
        .waddr(mt_wa), .wdata(mt_wd), .raddr(mt_ra), .rdata(mt_rd));
    gtq_ram #(.WIDTH(MW), .DEPTH(CAPACITY)) u_node_member (.aclk(aclk), .we(nm_we),
        .waddr(nm_wa), .wdata(nm_wd), .raddr(nm_ra), .rdata(nm_rd));
    gtq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node_next (.aclk(aclk), .we(nx_we),
        .waddr(nx_wa), .wdata(nx_wd), .raddr(nx_ra), .rdata(nx_rd));
    gtq_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_free_slots (.aclk(aclk), .we(fs_we),
        .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd));
    gtq_ram #(.WIDTH(NW), .DEPTH(TEAMS)) u_team_head (.aclk(aclk), .we(th_we),
        .waddr(th_wa), .wdata(th_wd), .raddr(th_ra), .rdata(th_rd));
    gtq_ram #(.WIDTH(NW), .DEPTH(TEAMS)) u_team_tail (.aclk(aclk), .we(tt_we),
        .waddr(tt_wa), .wdata(tt_wd), .raddr(tt_ra), .rdata(tt_rd));
    gtq_ram #(.WIDTH(1), .DEPTH(TEAMS)) u_team_wait (.aclk(aclk), .we(tw_we),
        .waddr(tw_wa), .wdata(tw_wd), .raddr(tw_ra), .rdata(tw_rd));
    gtq_ram #(.WIDTH(TW), .DEPTH(TEAMS)) u_active (.aclk(aclk), .we(at_we),
        .waddr(at_wa), .wdata(at_wd), .raddr(at_ra), .rdata(at_rd));

    logic out_free;
    logic s_acc;
    assign out_free = !ov_reg || m_tready;
    // Accept only while idle and the result slot will be free.
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign s_acc    = s_tvalid && s_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, omem_reg, ost_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            op_reg    <= OP_ASSIGN;
            swp_reg   <= '0;
            fcnt_reg  <= (NW + 1)'(CAPACITY);
            rptr_reg  <= '0;
            wptr_reg  <= '0;
            acnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            swp_reg   <= swp_next;
            fcnt_reg  <= fcnt_next;
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            acnt_reg  <= acnt_next;
            ov_reg    <= ov_next;
        end
        mem_reg  <= mem_next;
        team_reg <= team_next;
        node_reg <= node_next;
        ost_reg  <= ost_next;
        omem_reg <= omem_next;
        wait_reg <= wait_next;
    end

    always_comb begin
        state_next = state_reg;
        op_next = op_reg; mem_next = mem_reg;
        team_next = team_reg; node_next = node_reg; fcnt_next = fcnt_reg;
        rptr_next = rptr_reg; wptr_next = wptr_reg; acnt_next = acnt_reg;
        swp_next = swp_reg; ost_next = ost_reg; omem_next = omem_reg;
        wait_next = wait_reg;
        ov_next = ov_reg && !m_tready;
        mt_we = 1'b0; mt_wa = mem_reg; mt_wd = '0; mt_ra = mem_reg;
        nm_we = 1'b0; nm_wa = node_reg; nm_wd = mem_reg; nm_ra = th_rd;
        nx_we = 1'b0; nx_wa = node_reg; nx_wd = '0; nx_ra = th_rd;
        fs_we = 1'b0; fs_wa = fcnt_reg[NW-1:0]; fs_wd = node_reg;
        fs_ra = fcnt_reg[NW-1:0] - 1'b1;
        th_we = 1'b0; th_wa = team_reg; th_wd = node_reg; th_ra = at_rd;
        tt_we = 1'b0; tt_wa = team_reg; tt_wd = node_reg; tt_ra = mt_rd;
        tw_we = 1'b0; tw_wa = team_reg; tw_wd = 1'b0; tw_ra = mt_rd;
        at_we = 1'b0; at_wa = wptr_reg; at_wd = team_reg; at_ra = rptr_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    op_next  = s_tdata[1:0];
                    mem_next = s_tdata[2 +: MW];
                    mt_ra    = s_tdata[2 +: MW];
                    case (s_tdata[1:0])
                        OP_ASSIGN: begin
                            // Ignore team numbers beyond the table.
                            mt_we = ({{(TW + 1 > TEAM_FIELD ? TW + 1 - TEAM_FIELD : 0)
                                {1'b0}}, s_tdata[14 +: TEAM_FIELD]} < TEAMS);
                            mt_wa = s_tdata[2 +: MW];
                            mt_wd = TW'(s_tdata[14 +: TEAM_FIELD]);
                            ost_next = ST_DONE; omem_next = '0; ov_next = 1'b1;
                        end
                        OP_ENQUEUE: state_next = S_ENQ_RD;
                        OP_DEQUEUE: begin
                            if (acnt_reg == '0) begin
                                ost_next = ST_EMPTY; omem_next = '0; ov_next = 1'b1;
                            end else begin
                                state_next = S_DEQ_RD1;
                            end
                        end
                        default: begin
                            swp_next = '0; state_next = S_CLEAR;
                        end
                    endcase
                end
            end
            S_ENQ_RD: begin
                // Team is known now; fetch its waiting bit, tail and a free node.
                team_next = mt_rd;
                if (fcnt_reg == '0) begin
                    state_next = S_OUT; ost_next = ST_FULL; omem_next = '0;
                end else begin
                    state_next = S_ENQ_WR; ost_next = ST_DONE;
                end
            end
            S_ENQ_WR: begin
                node_next = fs_rd;
                fcnt_next = fcnt_reg - 1'b1;
                nm_we = 1'b1; nm_wa = fs_rd;
                nx_we = 1'b1; nx_wa = fs_rd;
                tt_we = 1'b1; tt_wd = fs_rd;
                if (tw_rd[0]) begin
                    // Link behind the current tail of the team.
                    nx_wa = tt_rd; nx_wd = fs_rd;
                    nx_we = 1'b1;
                    nm_we = 1'b1;
                end else begin
                    th_we = 1'b1; th_wd = fs_rd;
                    tw_we = 1'b1; tw_wd = 1'b1;
                    if (acnt_reg < (TW + 1)'(TEAMS)) begin
                        at_we = 1'b1;
                        wptr_next = wptr_reg + 1'b1;
                        acnt_next = acnt_reg + 1'b1;
                    end
                end
                state_next = S_OUT; omem_next = '0;
            end
            S_DEQ_RD1: begin
                // Active team arrives; look up its head and tail.
                team_next = at_rd;
                tt_ra = at_rd;
                state_next = S_DEQ_RD2;
            end
            S_DEQ_RD2: begin
                // Head node arrives; read its member and successor.
                node_next = th_rd;
                wait_next = (th_rd == tt_rd);
                state_next = S_DEQ_WR;
            end
            S_DEQ_WR: begin
                omem_next = nm_rd; ost_next = ST_DONE;
                if (fcnt_reg < (NW + 1)'(CAPACITY)) begin
                    fs_we = 1'b1;
                    fcnt_next = fcnt_reg + 1'b1;
                end
                if (wait_reg) begin
                    tw_we = 1'b1; tw_wd = 1'b0;
                    rptr_next = rptr_reg + 1'b1;
                    acnt_next = acnt_reg - 1'b1;
                end else begin
                    th_we = 1'b1; th_wd = nx_rd;
                end
                state_next = S_OUT;
            end
            S_CLEAR: begin
                // Sweep the membership, free-slot and waiting tables back to their reset contents.
                mt_we = (swp_reg < (SW + 1)'(MEMBERS)); mt_wa = swp_reg[MW-1:0];
                fs_we = (swp_reg < (SW + 1)'(CAPACITY)); fs_wa = swp_reg[NW-1:0];
                fs_wd = swp_reg[NW-1:0];
                tw_we = (swp_reg < (SW + 1)'(TEAMS)); tw_wa = swp_reg[TW-1:0];
                swp_next = swp_reg + 1'b1;
                if (swp_reg == (SW + 1)'(SWEEP - 1)) begin
                    fcnt_next = (NW + 1)'(CAPACITY);
                    rptr_next = '0; wptr_next = '0; acnt_next = '0;
                    if (op_reg == OP_CLEAR) begin
                        state_next = S_OUT; ost_next = ST_DONE; omem_next = '0;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (out_free) begin
                    ov_next = 1'b1; state_next = S_IDLE; op_next = OP_ASSIGN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

>>> hw/rtl/gtq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> bench/gtq_checker.sv
// Checker for the team queue: watches both channels, predicts results, compares.
`timescale 1ns / 1ps
module gtq_checker
    import gtq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending
);
    typedef struct packed {
        logic [1:0]    status;
        logic [MW-1:0] member;
    } outcome_t;

    logic [TW-1:0] team_of [MEMBERS];
    logic [MW-1:0] slot_member [CAPACITY];
    logic [NW-1:0] slot_next [CAPACITY];
    logic [NW-1:0] free_stack [CAPACITY];
    int            free_left;
    logic [NW-1:0] head_of [TEAMS];
    logic [NW-1:0] tail_of [TEAMS];
    logic          waiting [TEAMS];
    logic [TW-1:0] team_fifo [TEAMS];
    int            fifo_rd, fifo_wr, fifo_len;
    outcome_t      outcomes [$];

    function automatic void wipe_tables();
        for (int i = 0; i < MEMBERS; i++) team_of[i] = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            free_stack[i]  = NW'(i);
            slot_member[i] = '0;
            slot_next[i]   = '0;
        end
        for (int i = 0; i < TEAMS; i++) begin
            waiting[i]   = 1'b0;
            head_of[i]   = '0;
            tail_of[i]   = '0;
            team_fifo[i] = '0;
        end
        free_left = CAPACITY;
        fifo_rd = 0;
        fifo_wr = 0;
        fifo_len = 0;
    endfunction

    function automatic outcome_t apply_op(logic [23:0] word);
        logic [1:0]    op;
        logic [MW-1:0] mem;
        logic [9:0]    tid;
        logic [TW-1:0] tm;
        logic [NW-1:0] nd;
        outcome_t      o;
        op  = word[1:0];
        mem = word[13:2];
        tid = word[23:14];
        o   = '{status: ST_DONE, member: '0};
        case (op)
            OP_ASSIGN: begin
                if (tid < TEAMS) team_of[mem] = TW'(tid);
            end
            OP_ENQUEUE: begin
                tm = team_of[mem];
                if (free_left == 0) begin
                    o.status = ST_FULL;
                end else begin
                    free_left--;
                    nd = free_stack[free_left];
                    slot_member[nd] = mem;
                    slot_next[nd] = '0;
                    if (waiting[tm]) begin
                        slot_next[tail_of[tm]] = nd;
                        tail_of[tm] = nd;
                    end else begin
                        head_of[tm] = nd;
                        tail_of[tm] = nd;
                        waiting[tm] = 1'b1;
                        if (fifo_len < TEAMS) begin
                            team_fifo[fifo_wr] = tm;
                            fifo_wr = (fifo_wr + 1) % TEAMS;
                            fifo_len++;
                        end
                    end
                end
            end
            OP_DEQUEUE: begin
                if (fifo_len == 0) begin
                    o.status = ST_EMPTY;
                end else begin
                    tm = team_fifo[fifo_rd];
                    nd = head_of[tm];
                    o.member = slot_member[nd];
                    if (free_left < CAPACITY) begin
                        free_stack[free_left] = nd;
                        free_left++;
                    end
                    if (nd == tail_of[tm]) begin
                        waiting[tm] = 1'b0;
                        fifo_rd = (fifo_rd + 1) % TEAMS;
                        fifo_len--;
                    end else begin
                        head_of[tm] = slot_next[nd];
                    end
                end
            end
            default: wipe_tables();
        endcase
        return o;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        wipe_tables();
    end

    assign pending = outcomes.size();

    // Sample on the edge; the predictor updates in order of acceptance.
    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) outcomes.push_back(apply_op(s_tdata));
            if (m_tvalid && m_tready) begin
                if (outcomes.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = outcomes.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  m_tdata[1:0], want.status));
                    if (m_tdata[13:2] !== want.member)
                        report_mismatch($sformatf("member %0d, want %0d",
                                                  m_tdata[13:2], want.member));
                    if (m_tdata[15:14] !== 2'b00)
                        report_mismatch("pad bits not zero");
                end
            end
        end
    end
endmodule

>>> bench/tb_grouped_team_queue.sv
// Testbench top for the team queue: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module tb_grouped_team_queue;
    import gtq_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // opcode[1:0], member_id[13:2], team_id[23:14]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // status[1:0], out_member[13:2], zero[15:14]
    int          fail_count;
    int          pending;
    bit          calm_phase;    // no idling on either side
    bit          hold_results;  // long receiver hold-off
    int          calm_sent;

    grouped_team_queue DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    gtq_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop: a few clears plus ~700 items at worst-case stalls stay far below
    // this.
    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic logic [23:0] pack_op(logic [1:0] op, logic [11:0] mem,
                                             logic [9:0] tid);
        return {tid, mem, op};
    endfunction

    // Offer one transfer, idling at random first; hold it until accepted.
    task automatic send(logic [23:0] word);
        if (!calm_phase && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (calm_phase) calm_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Members are mostly drawn from a small pool so that teams gather queues.
    function automatic logic [11:0] pick_member();
        if ($urandom_range(9) < 8) return 12'($urandom_range(31));
        return 12'($urandom);
    endfunction

    function automatic logic [9:0] pick_team();
        if ($urandom_range(9) < 8) return 10'($urandom_range(7));
        return 10'($urandom);
    endfunction

    // Receiver: random stalls, one long hold-off, a stretch with none.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_results) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_results = 1'b0;
            end
            m_tready <= calm_phase || ($urandom_range(99) >= 38);
        end
    end

    initial begin
        int pick;
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        calm_phase   = 1'b0;
        hold_results = 1'b0;
        calm_sent    = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty dequeue, field extremes, three teams interleaved,
        // repeated member, clear.
        send(pack_op(OP_DEQUEUE, 12'hFFF, 10'h3FF));
        send(pack_op(OP_ASSIGN, 12'hFFF, 10'h3FF));
        send(pack_op(OP_ASSIGN, 12'd1, 10'd5));
        send(pack_op(OP_ASSIGN, 12'd2, 10'd5));
        send(pack_op(OP_ENQUEUE, 12'd0, 10'h3FF));
        send(pack_op(OP_ENQUEUE, 12'd1, 10'd0));
        send(pack_op(OP_ENQUEUE, 12'hFFF, 10'd0));
        send(pack_op(OP_ENQUEUE, 12'd2, 10'd0));
        send(pack_op(OP_ENQUEUE, 12'd1, 10'd0));
        send(pack_op(OP_ENQUEUE, 12'd3, 10'd0));
        send(pack_op(OP_ASSIGN, 12'd3, 10'd1023));
        repeat (7) send(pack_op(OP_DEQUEUE, 12'd0, 10'd0));
        send(pack_op(OP_ENQUEUE, 12'd1, 10'd0));
        send(pack_op(OP_CLEAR, 12'hAAA, 10'h155));
        send(pack_op(OP_ENQUEUE, 12'd1, 10'd0));
        send(pack_op(OP_DEQUEUE, 12'd0, 10'd0));
        drain();

        // Random mix, weighted toward enqueue/dequeue; the sender pauses
        // once for the queue to drain and once rides out a long hold-off.
        for (int n = 0; n < 680; n++) begin
            if (n == 200) drain();
            if (n == 350) hold_results = 1'b1;
            if (n == 450) calm_phase = 1'b1;
            if (calm_phase && calm_sent >= 120) calm_phase = 1'b0;
            pick = $urandom_range(99);
            if (pick < 15)
                send(pack_op(OP_ASSIGN, pick_member(), pick_team()));
            else if (pick < 60)
                send(pack_op(OP_ENQUEUE, pick_member(), 10'($urandom)));
            else if (pick < 99)
                send(pack_op(OP_DEQUEUE, 12'($urandom), 10'($urandom)));
            else
                send(pack_op(OP_CLEAR, 12'($urandom), 10'($urandom)));
        end
        drain();
        repeat (20) @(posedge aclk);

        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule
